FILE: sv/homography_inlier_scoring_top_macros.svh
// Assertion macros shared by the inlier scoring modules.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef HOMOGRAPHY_INLIER_SCORING_TOP_MACROS_SVH
`define HOMOGRAPHY_INLIER_SCORING_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset
`define HIS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define HIS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/his_pkg.sv
// Shared constants, types and helpers for the homography inlier scorer.
// No dependencies; every other file but the assertion macros header imports this package.
package his_pkg;

  // Field and register widths
  localparam int COEF_BITS = 21;
  localparam int MAX_PAIRS = 1024;
  localparam int CFG_W     = 3 * COEF_BITS;
  localparam int CFG_IDX_W = 2;
  localparam int THR_W     = 16;
  localparam int PT_W      = 16;
  localparam int TOT_W     = 11;
  localparam int RATIO_W   = 17;
  localparam int CNT_W     = $clog2(MAX_PAIRS + 1);

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_COEF_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COEF_Y = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_COEF_W = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_THRESH = CFG_IDX_W'(3);

  // Shared multiplier and accumulator
  localparam int EX_W    = 18;
  localparam int MUL_B_W = EX_W;
  localparam int MUL_A_W = (COEF_BITS > EX_W) ? COEF_BITS : EX_W;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = PROD_W + 2;

  // Fixed-point alignment shifts
  localparam int H2_SH    = 16;
  localparam int H8_SH    = 8;
  localparam int NUM_SH   = 8;
  localparam int RATIO_SH = 16;

  // Shared divider
  localparam int QUO_W     = 24;
  localparam int DIV_D_W   = ACC_W - 1;
  localparam int DIV_N_W   = ACC_W - 1 + NUM_SH;
  localparam int DSH_W     = DIV_D_W + QUO_W;
  localparam int DIV_CNT_W = $clog2(QUO_W + 1);
  localparam int E_W       = QUO_W + 1;

  typedef struct packed {
    logic [CFG_W-1:0] coef_x;
    logic [CFG_W-1:0] coef_y;
    logic [CFG_W-1:0] coef_w;
    logic [THR_W-1:0] thr;
  } cfg_t;

  typedef struct packed {
    logic                      mul_en;
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
    logic                      acc_en;
    logic                      keep;
    logic                      use_prod;
    logic                      sub;
    logic signed [ACC_W-1:0]   addend;
  } mac_op_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] num;
    logic [DIV_D_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic             ovf;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

  // Pull coefficient k out of a packed coefficient register
  function automatic logic signed [COEF_BITS-1:0] coef_fld(input logic [CFG_W-1:0] r,
                                                           input logic [1:0] k);
    return r[k*COEF_BITS +: COEF_BITS];
  endfunction

endpackage

FILE: sv/his_pair_if.sv
// Input channel of the scorer: one matched point pair per word.
// Depends on his_pkg for field widths.
interface his_pair_if import his_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PT_W-1:0] src_x;
  logic [PT_W-1:0] src_y;
  logic [PT_W-1:0] dst_x;
  logic [PT_W-1:0] dst_y;
  logic            pair_valid;
  logic            last_pair;

  modport source (output valid, src_x, src_y, dst_x, dst_y, pair_valid, last_pair,
                  input ready);
  modport sink (input valid, src_x, src_y, dst_x, dst_y, pair_valid, last_pair,
                output ready);
endinterface

FILE: sv/his_result_if.sv
// Result channel of the scorer: one score word per pair.
// Depends on his_pkg for field widths.
interface his_result_if import his_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               is_inlier;
  logic               was_counted;
  logic [TOT_W-1:0]   inlier_total;
  logic [TOT_W-1:0]   used_total;
  logic [RATIO_W-1:0] inlier_ratio;
  logic               run_end;

  modport source (output valid, is_inlier, was_counted, inlier_total, used_total,
                  inlier_ratio, run_end, input ready);
  modport sink (input valid, is_inlier, was_counted, inlier_total, used_total,
                inlier_ratio, run_end, output ready);
endinterface

FILE: sv/his_mac.sv
// Shared signed multiplier with a registered product and an accumulator.
// Depends on his_pkg (mac_op_t, widths).
module his_mac import his_pkg::*; (
  input  logic                    clk,
  input  mac_op_t                 op,
  output logic signed [ACC_W-1:0] acc
);

  logic signed [MUL_A_W-1:0] op_a;
  logic signed [MUL_B_W-1:0] op_b;
  logic signed [ACC_W-1:0]   op_addend;
  logic signed [PROD_W-1:0]  a_x;
  logic signed [PROD_W-1:0]  b_x;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   prod_x;
  logic signed [ACC_W-1:0]   base;
  logic signed [ACC_W-1:0]   term;

  assign op_a      = op.a;
  assign op_b      = op.b;
  assign op_addend = op.addend;
  assign a_x       = PROD_W'(op_a);
  assign b_x       = PROD_W'(op_b);
  assign prod_x    = ACC_W'(prod);

  // Pick the accumulator base and the signed product term
  always_comb begin
    base = op.keep ? acc : op_addend;
    if (!op.use_prod) begin
      term = '0;
    end else if (op.sub) begin
      term = -prod_x;
    end else begin
      term = prod_x;
    end
  end

  // Register the product, then fold it into the accumulator
  always_ff @(posedge clk) begin
    if (op.mul_en) begin
      prod <= a_x * b_x;
    end
    if (op.acc_en) begin
      acc <= base + term;
    end
  end

endmodule

FILE: sv/his_div.sv
// Shared restoring divider: 24 quotient bits, one bit a cycle, with an
// up-front overflow test. Depends on his_pkg and the assertion macros.
`include "homography_inlier_scoring_top_macros.svh"

module his_div import his_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  typedef enum logic {D_IDLE, D_RUN} dstate_t;

  dstate_t              state;
  logic [DIV_N_W-1:0]   rem;
  logic [DSH_W-1:0]     dsh;
  logic [QUO_W-1:0]     quo;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 ovf;
  logic                 done;
  logic                 ge;

  // Trial compare of the remainder against the shifted divisor
  assign ge = (DSH_W'(rem) >= dsh);

  assign rsp.done = done;
  assign rsp.ovf  = ovf;
  assign rsp.quo  = quo;

  // Step 0 tests for a quotient of 2^24 or more, steps 1..24 make the bits
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        D_IDLE: begin
          if (req.start) begin
            rem   <= req.num;
            dsh   <= {req.den, {QUO_W{1'b0}}};
            quo   <= '0;
            cnt   <= '0;
            ovf   <= 1'b0;
            state <= D_RUN;
          end
        end
        D_RUN: begin
          dsh <= dsh >> 1;
          cnt <= cnt + 1'b1;
          if (cnt == '0) begin
            ovf <= ge;
            if (ge) begin
              done  <= 1'b1;
              state <= D_IDLE;
            end
          end else begin
            if (ge) begin
              rem <= rem - dsh[DIV_N_W-1:0];
            end
            quo <= {quo[QUO_W-2:0], ge};
            if (cnt == DIV_CNT_W'(QUO_W)) begin
              done  <= 1'b1;
              state <= D_IDLE;
            end
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

  `HIS_ASSERT_IMP(a_div_start_idle, req.start, state == D_IDLE, "divider started while busy")
  `HIS_ASSERT_IMP(a_div_done_idle, done, state == D_IDLE, "divider done but still running")
  `HIS_ASSERT_NXT(a_div_last_step, state == D_RUN && cnt == DIV_CNT_W'(QUO_W), done, "divider overran its last step")

endmodule

FILE: sv/his_seq.sv
// Sequencer of the scorer: drives the shared multiply-accumulate and divider
// units, keeps the run counters and the result register.
// Depends on his_pkg, his_mac, his_div, the channel interfaces and the macros.
`include "homography_inlier_scoring_top_macros.svh"

module his_seq import his_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  his_pair_if.sink      pair,
  his_result_if.source  result
);

  typedef enum logic [4:0] {
    S_IDLE, S_DEN0, S_DEN1, S_DEN2, S_NX0, S_NX1, S_NY0, S_NY1,
    S_DIVX, S_SQX, S_SQX1, S_DIVY, S_SQY, S_SQY1, S_THR, S_CMP,
    S_CNT, S_RSTART, S_RDIV, S_OUT
  } state_t;

  state_t                  state;
  logic [PT_W-1:0]         sx;
  logic [PT_W-1:0]         sy;
  logic [PT_W-1:0]         dx;
  logic [PT_W-1:0]         dy;
  logic                    valid_r;
  logic                    last_r;
  logic signed [ACC_W-1:0] den_r;
  logic                    qsgn;
  logic signed [EX_W-1:0]  ex_r;
  logic                    far_r;
  logic                    inlier_r;
  logic [RATIO_W-1:0]      ratio_r;
  logic [CNT_W-1:0]        inlier_counter;
  logic [CNT_W-1:0]        used_counter;

  logic                    res_valid;
  logic                    res_inlier;
  logic                    res_counted;
  logic [TOT_W-1:0]        res_inl_tot;
  logic [TOT_W-1:0]        res_used_tot;
  logic [RATIO_W-1:0]      res_ratio;
  logic                    res_end;

  mac_op_t                 mac_op;
  logic signed [ACC_W-1:0] acc;
  div_req_t                div_req;
  div_rsp_t                div_rsp;

  logic signed [COEF_BITS-1:0] h0, h1, h2, h3, h4, h5, h6, h7, h8;
  logic [ACC_W-1:0]            acc_mag;
  logic [ACC_W-1:0]            den_mag;
  logic [PT_W-1:0]             dsel;
  logic [E_W-1:0]              q_mag;
  logic signed [E_W-1:0]       q_s;
  logic signed [E_W-1:0]       e_s;
  logic                        near;
  logic                        far_now;
  logic                        out_free;

  his_mac u_mac (
    .clk (clk),
    .op  (mac_op),
    .acc (acc)
  );

  his_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Unpack the coefficients
  assign h0 = coef_fld(cfg.coef_x, 2'd0);
  assign h1 = coef_fld(cfg.coef_x, 2'd1);
  assign h2 = coef_fld(cfg.coef_x, 2'd2);
  assign h3 = coef_fld(cfg.coef_y, 2'd0);
  assign h4 = coef_fld(cfg.coef_y, 2'd1);
  assign h5 = coef_fld(cfg.coef_y, 2'd2);
  assign h6 = coef_fld(cfg.coef_w, 2'd0);
  assign h7 = coef_fld(cfg.coef_w, 2'd1);
  assign h8 = coef_fld(cfg.coef_w, 2'd2);

  assign pair.ready = (state == S_IDLE);
  assign out_free   = !res_valid || result.ready;

  // Magnitudes for the unsigned divider
  assign acc_mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
  assign den_mag = den_r[ACC_W-1] ? ACC_W'(-den_r) : ACC_W'(den_r);

  // Signed projected coordinate minus destination; flag points far away
  always_comb begin
    dsel    = (state == S_DIVY) ? dy : dx;
    q_mag   = {2'b00, div_rsp.quo[QUO_W-2:0]};
    q_s     = qsgn ? -q_mag : q_mag;
    e_s     = q_s - E_W'(dsel);
    near    = (e_s[E_W-1:EX_W-2] == '0) || (e_s[E_W-1:EX_W-2] == '1);
    far_now = div_rsp.ovf || div_rsp.quo[QUO_W-1] || !near;
  end

  // Micro-operation of the shared multiply-accumulate for each step
  always_comb begin
    mac_op = '0;
    case (state)
      S_DEN0: begin
        mac_op.mul_en = 1'b1;
        mac_op.a      = MUL_A_W'(h6);
        mac_op.b      = MUL_B_W'(sx);
        mac_op.acc_en = 1'b1;
        mac_op.addend = ACC_W'(h8) <<< H8_SH;
      end
      S_DEN1: begin
        mac_op.mul_en   = 1'b1;
        mac_op.a        = MUL_A_W'(h7);
        mac_op.b        = MUL_B_W'(sy);
        mac_op.acc_en   = 1'b1;
        mac_op.keep     = 1'b1;
        mac_op.use_prod = 1'b1;
      end
      S_DEN2: begin
        mac_op.mul_en   = 1'b1;
        mac_op.a        = MUL_A_W'(h0);
        mac_op.b        = MUL_B_W'(sx);
        mac_op.acc_en   = 1'b1;
        mac_op.keep     = 1'b1;
        mac_op.use_prod = 1'b1;
      end
      S_NX0: begin
        mac_op.mul_en   = 1'b1;
        mac_op.a        = MUL_A_W'(h1);
        mac_op.b        = MUL_B_W'(sy);
        mac_op.acc_en   = 1'b1;
        mac_op.use_prod = 1'b1;
        mac_op.addend   = ACC_W'(h2) <<< H2_SH;
      end
      S_NX1: begin
        mac_op.mul_en   = 1'b1;
        mac_op.a        = MUL_A_W'(h3);
        mac_op.b        = MUL_B_W'(sx);
        mac_op.acc_en   = 1'b1;
        mac_op.keep     = 1'b1;
        mac_op.use_prod = 1'b1;
      end
      S_NY0: begin
        mac_op.mul_en   = 1'b1;
        mac_op.a        = MUL_A_W'(h4);
        mac_op.b        = MUL_B_W'(sy);
        mac_op.acc_en   = 1'b1;
        mac_op.use_prod = 1'b1;
        mac_op.addend   = ACC_W'(h5) <<< H2_SH;
      end
      S_NY1: begin
        mac_op.acc_en   = 1'b1;
        mac_op.keep     = 1'b1;
        mac_op.use_prod = 1'b1;
      end
      S_SQX, S_SQY: begin
        mac_op.mul_en = 1'b1;
        mac_op.a      = MUL_A_W'(ex_r);
        mac_op.b      = ex_r;
      end
      S_SQX1: begin
        mac_op.acc_en   = 1'b1;
        mac_op.use_prod = 1'b1;
      end
      S_SQY1: begin
        mac_op.mul_en   = 1'b1;
        mac_op.a        = MUL_A_W'(cfg.thr);
        mac_op.b        = MUL_B_W'(cfg.thr);
        mac_op.acc_en   = 1'b1;
        mac_op.keep     = 1'b1;
        mac_op.use_prod = 1'b1;
      end
      S_THR: begin
        mac_op.acc_en   = 1'b1;
        mac_op.keep     = 1'b1;
        mac_op.use_prod = 1'b1;
        mac_op.sub      = 1'b1;
      end
      default: mac_op = '0;
    endcase
  end

  // Divider requests: x and y projections, then the run ratio
  always_comb begin
    div_req = '0;
    case (state)
      S_NY0, S_SQX: begin
        div_req.start = (den_r != '0);
        div_req.num   = {acc_mag[ACC_W-2:0], {NUM_SH{1'b0}}};
        div_req.den   = den_mag[DIV_D_W-1:0];
      end
      S_RSTART: begin
        div_req.start = (used_counter != '0);
        div_req.num   = DIV_N_W'({inlier_counter, {RATIO_SH{1'b0}}});
        div_req.den   = DIV_D_W'(used_counter);
      end
      default: div_req = '0;
    endcase
  end

  // Sequencer, counters and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      res_valid      <= 1'b0;
      inlier_counter <= '0;
      used_counter   <= '0;
    end else begin
      if (result.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pair.valid) begin
            sx       <= pair.src_x;
            sy       <= pair.src_y;
            dx       <= pair.dst_x;
            dy       <= pair.dst_y;
            valid_r  <= pair.pair_valid;
            last_r   <= pair.last_pair;
            inlier_r <= 1'b0;
            far_r    <= 1'b0;
            ratio_r  <= '0;
            state    <= pair.pair_valid ? S_DEN0 : S_CNT;
          end
        end
        S_DEN0: state <= S_DEN1;
        S_DEN1: state <= S_DEN2;
        S_DEN2: state <= S_NX0;
        S_NX0: begin
          den_r <= acc;
          state <= S_NX1;
        end
        S_NX1: state <= S_NY0;
        S_NY0: begin
          // A zero denominator leaves the pair an outlier
          qsgn  <= acc[ACC_W-1] ^ den_r[ACC_W-1];
          state <= (den_r == '0) ? S_CNT : S_NY1;
        end
        S_NY1: state <= S_DIVX;
        S_DIVX: begin
          if (div_rsp.done) begin
            ex_r  <= e_s[EX_W-1:0];
            far_r <= far_r | far_now;
            state <= S_SQX;
          end
        end
        S_SQX: begin
          qsgn  <= acc[ACC_W-1] ^ den_r[ACC_W-1];
          state <= S_SQX1;
        end
        S_SQX1: state <= S_DIVY;
        S_DIVY: begin
          if (div_rsp.done) begin
            ex_r  <= e_s[EX_W-1:0];
            far_r <= far_r | far_now;
            state <= S_SQY;
          end
        end
        S_SQY:  state <= S_SQY1;
        S_SQY1: state <= S_THR;
        S_THR:  state <= S_CMP;
        S_CMP: begin
          // Accumulator holds d2 - t2 here
          inlier_r <= !far_r && acc[ACC_W-1];
          state    <= S_CNT;
        end
        S_CNT: begin
          if (valid_r) begin
            if (used_counter < CNT_W'(MAX_PAIRS)) begin
              used_counter <= used_counter + 1'b1;
            end
            if (inlier_r && (inlier_counter < CNT_W'(MAX_PAIRS))) begin
              inlier_counter <= inlier_counter + 1'b1;
            end
          end
          state <= last_r ? S_RSTART : S_OUT;
        end
        S_RSTART: state <= (used_counter != '0) ? S_RDIV : S_OUT;
        S_RDIV: begin
          if (div_rsp.done) begin
            ratio_r <= div_rsp.quo[RATIO_W-1:0];
            state   <= S_OUT;
          end
        end
        S_OUT: begin
          // Hold until the result register is free, then clear on run end
          if (out_free) begin
            res_valid    <= 1'b1;
            res_inlier   <= inlier_r;
            res_counted  <= valid_r;
            res_inl_tot  <= TOT_W'(inlier_counter);
            res_used_tot <= TOT_W'(used_counter);
            res_ratio    <= ratio_r;
            res_end      <= last_r;
            if (last_r) begin
              inlier_counter <= '0;
              used_counter   <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid        = res_valid;
  assign result.is_inlier    = res_inlier;
  assign result.was_counted  = res_counted;
  assign result.inlier_total = res_inl_tot;
  assign result.used_total   = res_used_tot;
  assign result.inlier_ratio = res_ratio;
  assign result.run_end      = res_end;

  `HIS_ASSERT_IMP(a_inl_le_used, state == S_OUT, inlier_counter <= used_counter, "more inliers than used pairs")
  `HIS_ASSERT_NXT(a_run_clear, state == S_OUT && last_r && out_free, used_counter == '0 && inlier_counter == '0, "counters not cleared after run end")
  `HIS_ASSERT_IMP(a_div_from, div_req.start, state == S_NY0 || state == S_SQX || state == S_RSTART, "divider started from a wrong step")

endmodule

FILE: sv/homography_inlier_scoring_top.sv
// Homography inlier scorer, top level: configuration registers and the sequencer.
// A used pair with a nonzero denominator makes two passes through the shared divider,
// one per projected coordinate; an unused pair skips them, and the last pair of a run
// adds a ratio division on the same divider when the run used any pair.
// One pair is in flight at a time; the next is taken as soon as its result is registered.
// Synchronous active-high reset: counters clear, threshold 16, coefficients 0.
module homography_inlier_scoring_top import his_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  his_pair_if.sink             pair,
  his_result_if.source         result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cfg_t cfg;

  // Register writes from the configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coef_x <= '0;
      cfg.coef_y <= '0;
      cfg.coef_w <= '0;
      cfg.thr    <= THR_W'(16);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COEF_X: cfg.coef_x <= cfg_data;
        REG_COEF_Y: cfg.coef_y <= cfg_data;
        REG_COEF_W: cfg.coef_w <= cfg_data;
        REG_THRESH: cfg.thr    <= cfg_data[THR_W-1:0];
        default:    cfg.thr    <= cfg.thr;
      endcase
    end
  end

  his_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .pair   (pair),
    .result (result)
  );

endmodule

FILE: tb/homography_inlier_scoring_top_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for homography_inlier_scoring_top: predicts every score word
// from its own fixed-point projection and compares it on the result channel.
// Depends on his_pkg, his_pair_if, his_result_if and the top module from the RTL.
module homography_inlier_scoring_top_test;
  import his_pkg::*;

  localparam int     CLK_HALF     = 4;
  localparam int     RESET_CYCLES = 8;
  localparam int     HOLD_CYCLES  = 600;
  localparam int     END_SETTLE   = 100;
  localparam int     MAX_REPORTS  = 10;
  localparam longint CYCLE_LIMIT  = 1_500_000;
  localparam longint QUO_HI       = 64'sd8388607;
  localparam longint QUO_LO       = -64'sd8388608;
  localparam longint ONE_Q16      = 65536;

  typedef enum int {HOMOG_AFFINE, HOMOG_PERSPECTIVE, HOMOG_NEGATED, HOMOG_RAW} homog_style_e;

  typedef struct packed {
    logic [PT_W-1:0] src_x;
    logic [PT_W-1:0] src_y;
    logic [PT_W-1:0] dst_x;
    logic [PT_W-1:0] dst_y;
    logic            pair_valid;
    logic            last_pair;
  } pair_t;

  typedef struct packed {
    logic               is_inlier;
    logic               was_counted;
    logic [TOT_W-1:0]   inlier_total;
    logic [TOT_W-1:0]   used_total;
    logic [RATIO_W-1:0] inlier_ratio;
    logic               run_end;
  } score_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 recv_ready = 1'b0;

  his_pair_if   pair_ch ();
  his_result_if res_ch ();

  assign res_ch.ready = recv_ready;

  homography_inlier_scoring_top DUT (
    .clk      (clk),
    .rst      (rst),
    .pair     (pair_ch),
    .result   (res_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Hypothesis registers and run counters as the block should hold them
  logic [CFG_W-1:0] hyp_x   = '0;
  logic [CFG_W-1:0] hyp_y   = '0;
  logic [CFG_W-1:0] hyp_w   = '0;
  logic [THR_W-1:0] hyp_thr = THR_W'(16);
  int               run_inliers = 0;
  int               run_used    = 0;

  score_t pending_scores[$];

  int     error_count    = 0;
  int     pairs_sent     = 0;
  int     results_seen   = 0;
  int     run_ends_seen  = 0;
  int     inliers_seen   = 0;
  int     configs_loaded = 0;
  longint cycle_count    = 0;

  // Sender and receiver pacing
  int   burst_left     = 0;
  bit   sender_gaps_on = 1'b1;
  bit   offering       = 1'b0;
  int   hold_requests  = 0;
  int   holds_granted  = 0;
  int   hold_left      = 0;
  int   pat_left       = 0;
  bit   pat_open       = 1'b1;

  always #CLK_HALF clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic longint coef_of(input logic [CFG_W-1:0] r, input int k);
    logic signed [COEF_BITS-1:0] f;
    f = r[k*COEF_BITS +: COEF_BITS];
    return longint'(f);
  endfunction

  function automatic logic [CFG_W-1:0] pack_coefs(input longint c0, input longint c1,
                                                  input longint c2);
    logic [COEF_BITS-1:0] f0, f1, f2;
    f0 = c0[COEF_BITS-1:0];
    f1 = c1[COEF_BITS-1:0];
    f2 = c2[COEF_BITS-1:0];
    return {f2, f1, f0};
  endfunction

  // Clip a quotient to the 24 bits the divider produces
  function automatic longint clip_quotient(input longint q);
    if (q > QUO_HI) return QUO_HI;
    if (q < QUO_LO) return QUO_LO;
    return q;
  endfunction

  // Project a source point; false when the denominator is zero
  function automatic logic project_point(input logic [PT_W-1:0] sx_in,
                                         input logic [PT_W-1:0] sy_in,
                                         output longint qx, output longint qy);
    longint sx, sy, nx, ny, den;
    sx = sx_in;
    sy = sy_in;
    nx = coef_of(hyp_x, 0) * sx + coef_of(hyp_x, 1) * sy + coef_of(hyp_x, 2) * 65536;
    ny = coef_of(hyp_y, 0) * sx + coef_of(hyp_y, 1) * sy + coef_of(hyp_y, 2) * 65536;
    den = coef_of(hyp_w, 0) * sx + coef_of(hyp_w, 1) * sy + coef_of(hyp_w, 2) * 256;
    qx = 0;
    qy = 0;
    if (den == 0) return 1'b0;
    qx = clip_quotient((nx * 256) / den);
    qy = clip_quotient((ny * 256) / den);
    return 1'b1;
  endfunction

  // Score one accepted pair and advance the run counters
  function automatic score_t score_pair(input pair_t p);
    score_t s;
    longint qx, qy, dx, dy, ex, ey, thr;
    logic   hit;
    hit = 1'b0;
    if (p.pair_valid) begin
      if (project_point(p.src_x, p.src_y, qx, qy)) begin
        dx  = p.dst_x;
        dy  = p.dst_y;
        ex  = qx - dx;
        ey  = qy - dy;
        thr = hyp_thr;
        hit = (ex * ex + ey * ey) < (thr * thr);
      end
      if (run_used < MAX_PAIRS) run_used++;
      if (hit && run_inliers < MAX_PAIRS) run_inliers++;
    end
    s.is_inlier    = hit;
    s.was_counted  = p.pair_valid;
    s.inlier_total = TOT_W'(run_inliers);
    s.used_total   = TOT_W'(run_used);
    s.inlier_ratio = '0;
    if (p.last_pair && run_used != 0)
      s.inlier_ratio = RATIO_W'((longint'(run_inliers) * ONE_Q16) / run_used);
    s.run_end = p.last_pair;
    if (p.last_pair) begin
      run_inliers = 0;
      run_used    = 0;
    end
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic int rnd_signed(input int m);
    return int'($urandom_range(0, 2 * m)) - m;
  endfunction

  function automatic logic [PT_W-1:0] to_point(input longint v);
    if (v < 0) return '0;
    if (v > 65535) return '1;
    return PT_W'(v);
  endfunction

  function automatic pair_t mk_pair(input int sx, input int sy, input int dx, input int dy,
                                    input logic used, input logic last);
    pair_t p;
    p.src_x      = PT_W'(sx);
    p.src_y      = PT_W'(sy);
    p.dst_x      = PT_W'(dx);
    p.dst_y      = PT_W'(dy);
    p.pair_valid = used;
    p.last_pair  = last;
    return p;
  endfunction

  // Mostly pairs aimed near the projection, some unused or pure noise
  function automatic pair_t random_pair(input logic last);
    pair_t  p;
    longint qx, qy;
    int     r, pick;
    pick         = $urandom_range(0, 19);
    p.src_x      = $urandom_range(0, 65535);
    p.src_y      = $urandom_range(0, 65535);
    p.dst_x      = $urandom_range(0, 65535);
    p.dst_y      = $urandom_range(0, 65535);
    p.pair_valid = 1'b1;
    p.last_pair  = last;
    if (pick < 2) begin
      p.pair_valid = 1'b0;
    end else if (pick < 4) begin
      p.pair_valid = $urandom_range(0, 1);
    end else if (project_point(p.src_x, p.src_y, qx, qy)) begin
      r       = (hyp_thr > 300) ? 300 : int'(hyp_thr);
      p.dst_x = to_point(qx + rnd_signed(r + 2));
      p.dst_y = to_point(qy + rnd_signed(r + 2));
    end
    return p;
  endfunction

  // Offer one pair, wait for it to be taken, queue its score
  task automatic send_pair(input pair_t p);
    if (sender_gaps_on && burst_left == 0) begin
      if (offering) pair_ch.valid <= 1'b0;
      offering = 1'b0;
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(13, 90) : $urandom_range(1, 12))
        @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
    end
    if (burst_left > 0) burst_left--;
    pair_ch.valid      <= 1'b1;
    pair_ch.src_x      <= p.src_x;
    pair_ch.src_y      <= p.src_y;
    pair_ch.dst_x      <= p.dst_x;
    pair_ch.dst_y      <= p.dst_y;
    pair_ch.pair_valid <= p.pair_valid;
    pair_ch.last_pair  <= p.last_pair;
    offering = 1'b1;
    @(posedge clk);
    while (!pair_ch.ready) @(posedge clk);
    pending_scores.push_back(score_pair(p));
    pairs_sent++;
  endtask

  // Drop valid and wait until every queued score has come back
  task automatic wait_idle();
    if (offering) pair_ch.valid <= 1'b0;
    offering = 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
  endtask

  // Write all four registers back to back; block must be idle
  task automatic load_config(input logic [CFG_W-1:0] cx, input logic [CFG_W-1:0] cy,
                             input logic [CFG_W-1:0] cw, input logic [THR_W-1:0] thr);
    logic [CFG_W-1:0] thr_word;
    thr_word             = CFG_W'({$urandom, $urandom});
    thr_word[THR_W-1:0]  = thr;
    hyp_x   = cx;
    hyp_y   = cy;
    hyp_w   = cw;
    hyp_thr = thr;
    configs_loaded++;
    cfg_we    <= 1'b1;
    cfg_index <= REG_COEF_X;
    cfg_data  <= cx;
    @(posedge clk);
    cfg_index <= REG_COEF_Y;
    cfg_data  <= cy;
    @(posedge clk);
    cfg_index <= REG_COEF_W;
    cfg_data  <= cw;
    @(posedge clk);
    cfg_index <= REG_THRESH;
    cfg_data  <= thr_word;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_identity(input logic [THR_W-1:0] thr);
    load_config(pack_coefs(ONE_Q16, 0, 0), pack_coefs(0, ONE_Q16, 0),
                pack_coefs(0, 0, ONE_Q16), thr);
  endtask

  task automatic load_random_config(input homog_style_e style);
    longint           a0, a1, a2, b0, b1, b2, w0, w1, w2, sgn;
    logic [CFG_W-1:0] rx, ry, rw;
    logic [THR_W-1:0] thr;
    a0 = ONE_Q16 + rnd_signed(6554);
    a1 = rnd_signed(6554);
    a2 = rnd_signed(16000);
    b0 = rnd_signed(6554);
    b1 = ONE_Q16 + rnd_signed(6554);
    b2 = rnd_signed(16000);
    w0 = 0;
    w1 = 0;
    w2 = ONE_Q16;
    if (style != HOMOG_AFFINE) begin
      w0 = rnd_signed(40);
      w1 = rnd_signed(40);
      w2 = ONE_Q16 + rnd_signed(3000);
    end
    // same projection with every term negated: negative denominators
    sgn = (style == HOMOG_NEGATED) ? -1 : 1;
    rx  = pack_coefs(sgn * a0, sgn * a1, sgn * a2);
    ry  = pack_coefs(sgn * b0, sgn * b1, sgn * b2);
    rw  = pack_coefs(sgn * w0, sgn * w1, sgn * w2);
    if (style == HOMOG_RAW) begin
      rx = CFG_W'({$urandom, $urandom});
      ry = CFG_W'({$urandom, $urandom});
      rw = CFG_W'({$urandom, $urandom});
    end
    case ($urandom_range(0, 5))
      0:       thr = '0;
      1:       thr = '1;
      2:       thr = THR_W'(1);
      5:       thr = $urandom_range(0, 65535);
      default: thr = $urandom_range(2, 64);
    endcase
    load_config(rx, ry, rw, thr);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset coefficients give a zero denominator everywhere: all outliers
  task automatic test_reset_defaults();
    send_pair(mk_pair(100, 200, 100, 200, 1'b1, 1'b0));
    send_pair(mk_pair(0, 0, 0, 0, 1'b1, 1'b0));
    send_pair(mk_pair(5, 5, 5, 5, 1'b0, 1'b1));
  endtask

  // Identity mapping: field extremes and both sides of the threshold
  task automatic test_identity_threshold();
    wait_idle();
    load_identity(THR_W'(16));
    send_pair(mk_pair(0, 0, 0, 0, 1'b1, 1'b0));
    send_pair(mk_pair(65535, 65535, 65535, 65535, 1'b1, 1'b0));
    send_pair(mk_pair(1000, 1000, 1015, 1000, 1'b1, 1'b0));
    send_pair(mk_pair(1000, 1000, 1016, 1000, 1'b1, 1'b0));
    send_pair(mk_pair(1000, 1000, 1011, 1012, 1'b1, 1'b0));
    send_pair(mk_pair(1000, 1000, 990, 1011, 1'b1, 1'b0));
    send_pair(mk_pair(65535, 0, 0, 65535, 1'b1, 1'b0));
    send_pair(mk_pair(0, 65535, 65535, 0, 1'b0, 1'b0));
    send_pair(mk_pair(300, 400, 300, 400, 1'b1, 1'b1));
    // zero threshold never passes, the widest one passes just inside it
    wait_idle();
    load_identity('0);
    send_pair(mk_pair(10, 10, 10, 10, 1'b1, 1'b1));
    wait_idle();
    load_identity('1);
    send_pair(mk_pair(0, 0, 65535, 0, 1'b1, 1'b1));
    send_pair(mk_pair(0, 0, 65534, 0, 1'b1, 1'b1));
  endtask

  // Denominator sx - 1024: zero at one point, tiny next to it
  task automatic test_zero_denominator();
    wait_idle();
    load_config(pack_coefs(ONE_Q16, 0, 0), pack_coefs(0, ONE_Q16, 0),
                pack_coefs(1, 0, -4), THR_W'(16));
    send_pair(mk_pair(1024, 50, 1024, 50, 1'b1, 1'b0));
    send_pair(mk_pair(1025, 50, 1025, 50, 1'b1, 1'b0));
    send_pair(mk_pair(0, 0, 0, 0, 1'b1, 1'b1));
  endtask

  // Coefficient extremes drive the quotient into both clip limits
  task automatic test_saturated_quotient();
    wait_idle();
    load_config(pack_coefs(1048575, 1048575, 1048575),
                pack_coefs(-1048576, -1048576, -1048576), pack_coefs(0, 0, 1), '1);
    send_pair(mk_pair(65535, 65535, 65535, 65535, 1'b1, 1'b0));
    send_pair(mk_pair(0, 0, 0, 0, 1'b1, 1'b1));
    wait_idle();
    load_config('1, '1, '1, THR_W'(16));
    send_pair(mk_pair(12345, 54321, 65535, 0, 1'b1, 1'b1));
  endtask

  // Runs with nothing used report a zero ratio
  task automatic test_empty_run();
    wait_idle();
    load_identity(THR_W'(16));
    send_pair(mk_pair(7, 7, 7, 7, 1'b0, 1'b0));
    send_pair(mk_pair(8, 8, 8, 8, 1'b0, 1'b1));
    send_pair(mk_pair(9, 9, 9, 9, 1'b0, 1'b1));
  endtask

  // One long run of inliers pushes both counters into saturation
  task automatic test_counter_saturation();
    pair_t p;
    int    k;
    wait_idle();
    load_identity(THR_W'(64));
    for (k = 0; k < MAX_PAIRS + 8; k++) begin
      p.src_x      = $urandom_range(0, 65535);
      p.src_y      = $urandom_range(0, 65535);
      p.dst_x      = to_point(longint'(p.src_x) + rnd_signed(40));
      p.dst_y      = to_point(longint'(p.src_y) + rnd_signed(40));
      p.pair_valid = (k % 200) != 7;
      p.last_pair  = (k == MAX_PAIRS + 7);
      send_pair(p);
    end
  endtask

  // Hold the result side for a long stretch while pairs keep coming
  task automatic test_result_backpressure();
    int k;
    wait_idle();
    load_identity(THR_W'(32));
    sender_gaps_on = 1'b0;
    hold_requests <= hold_requests + 1;
    for (k = 0; k < 16; k++) send_pair(random_pair(k == 15));
    sender_gaps_on = 1'b1;
  endtask

  // Random hypotheses, each carrying a few runs of mostly aimed pairs
  task automatic test_random_runs(input int n_items);
    int sent, phase_items, run_len, k, pick;
    sent = 0;
    while (sent < n_items) begin
      wait_idle();
      pick = $urandom_range(0, 9);
      if (pick < 4)      load_random_config(HOMOG_AFFINE);
      else if (pick < 7) load_random_config(HOMOG_PERSPECTIVE);
      else if (pick < 9) load_random_config(HOMOG_NEGATED);
      else               load_random_config(HOMOG_RAW);
      phase_items = 0;
      while (phase_items < 60 && sent < n_items) begin
        run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 20);
        for (k = 0; k < run_len; k++) send_pair(random_pair(k == run_len - 1));
        phase_items += run_len;
        sent        += run_len;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver pacing: long hold on request, otherwise open/stall pattern
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      recv_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      recv_ready <= 1'b0;
    end else if (holds_granted != hold_requests) begin
      holds_granted <= holds_granted + 1;
      hold_left     <= HOLD_CYCLES;
      recv_ready    <= 1'b0;
    end else begin
      if (pat_left == 0) begin
        pat_open = !pat_open;
        if (pat_open)
          pat_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 8);
        else
          pat_left = $urandom_range(1, 6);
      end else begin
        pat_left = pat_left - 1;
      end
      recv_ready <= pat_open;
    end
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  function automatic void note_failure(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // Compare each accepted score word with the oldest prediction
  always @(posedge clk) begin
    score_t got, want;
    if (!rst && res_ch.valid && recv_ready) begin
      got.is_inlier    = res_ch.is_inlier;
      got.was_counted  = res_ch.was_counted;
      got.inlier_total = res_ch.inlier_total;
      got.used_total   = res_ch.used_total;
      got.inlier_ratio = res_ch.inlier_ratio;
      got.run_end      = res_ch.run_end;
      results_seen++;
      if (got.run_end === 1'b1) run_ends_seen++;
      if (got.is_inlier === 1'b1) inliers_seen++;
      if (pending_scores.size() == 0) begin
        note_failure($sformatf("score word %0d arrived with nothing expected", results_seen));
      end else begin
        want = pending_scores.pop_front();
        if (got !== want)
          note_failure($sformatf({"score word %0d: expected inl=%0b cnt=%0b itot=%0d utot=%0d ",
                                  "ratio=%0d end=%0b, got inl=%0b cnt=%0b itot=%0d utot=%0d ",
                                  "ratio=%0d end=%0b"}, results_seen,
                                 want.is_inlier, want.was_counted, want.inlier_total,
                                 want.used_total, want.inlier_ratio, want.run_end,
                                 got.is_inlier, got.was_counted, got.inlier_total,
                                 got.used_total, got.inlier_ratio, got.run_end));
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d scores outstanding",
               cycle_count, pending_scores.size());
      $display("homography_inlier_scoring_top_test: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = REG_COEF_X;
    cfg_data           = '0;
    pair_ch.valid      = 1'b0;
    pair_ch.src_x      = '0;
    pair_ch.src_y      = '0;
    pair_ch.dst_x      = '0;
    pair_ch.dst_y      = '0;
    pair_ch.pair_valid = 1'b0;
    pair_ch.last_pair  = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_identity_threshold();
    test_zero_denominator();
    test_saturated_quotient();
    test_empty_run();
    test_counter_saturation();
    test_result_backpressure();
    test_random_runs(600);

    // let any stray word show up before closing
    wait_idle();
    repeat (END_SETTLE) @(posedge clk);
    if (pending_scores.size() != 0)
      note_failure($sformatf("%0d score words never arrived", pending_scores.size()));

    $display("Scored %0d pairs in %0d runs (%0d inliers) over %0d register settings,",
             pairs_sent, run_ends_seen, inliers_seen, configs_loaded);
    $display("with zero and clipped divisions, counter saturation and a long result hold;",
             " %0d failures", error_count);
    if (error_count == 0) begin
      $display("homography_inlier_scoring_top_test: clean");
    end else begin
      $display("homography_inlier_scoring_top_test: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/his_pkg.sv
sv/his_pair_if.sv
sv/his_result_if.sv
sv/his_mac.sv
sv/his_div.sv
sv/his_seq.sv
sv/homography_inlier_scoring_top.sv
tb/homography_inlier_scoring_top_test.sv
